/* rtl/mnrs_pkg.sv */
// Shared types and constants for the MIDI note router with sustain tracking.
`default_nettype none

package mnrs_pkg;

    localparam int NOTE_COUNT  = 128;
    localparam int GROUP_WIDTH = 64;
    localparam int GROUPS      = NOTE_COUNT / GROUP_WIDTH;

    localparam logic [13:0] WHEEL_CENTER = 14'd8192;

    localparam logic [6:0] CC_MOD       = 7'd1;
    localparam logic [6:0] CC_SUSTAIN   = 7'd64;
    localparam logic [6:0] CC_SOUND_OFF = 7'd120;
    localparam logic [6:0] CC_NOTES_OFF = 7'd123;

    // Result queue sizing: one input message makes at most three results.
    localparam int MAX_RESULTS = 3;
    localparam int RES_DEPTH   = 4;
    localparam int PTR_W       = $clog2(RES_DEPTH);
    localparam int CNT_W       = $clog2(RES_DEPTH + 1);
    localparam int NUM_W       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        MODE_NOTE_ON,
        MODE_NOTE_OFF,
        MODE_WHEEL,
        MODE_CONTROL,
        MODE_OTHER,
        MODE_CLEAR,
        MODE_PANIC
    } mode_t;

    typedef enum logic [2:0] {
        EV_NOTE_ON,
        EV_NOTE_OFF,
        EV_BEND,
        EV_MOD,
        EV_ALL_OFF,
        EV_RELEASE
    } event_kind_t;

    typedef enum logic [2:0] {
        REG_TARGET_CHANNEL,
        REG_CHANNEL_FILTER,
        REG_TRANSPOSE,
        REG_BEND_RANGE,
        REG_SUSTAIN_THRESHOLD
    } reg_index_t;

    typedef struct packed {
        logic [3:0]        target_channel;
        logic [4:0]        channel_filter;
        logic signed [6:0] transpose;
        logic [5:0]        bend_range;
        logic [6:0]        sustain_threshold;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [4:0]  midi_channel;
        logic [6:0]  data_number;
        logic [6:0]  data_value;
        logic [13:0] wheel_value;
    } msg_t;

    typedef struct packed {
        event_kind_t        event_kind;
        logic [3:0]         out_channel;
        logic [6:0]         note_pitch;
        logic [6:0]         note_velocity;
        logic [4:0]         source_channel;
        logic signed [19:0] bend_amount;
        logic [6:0]         modulation_amount;
        logic               group_index;
        logic [63:0]        release_mask;
        logic [31:0]        activity_count;
        logic               last_of_run;
    } result_t;

    typedef struct packed {
        logic [NUM_W-1:0]                count;
        result_t [MAX_RESULTS-1:0]       items;
    } push_t;

endpackage

`default_nettype wire

/* rtl/mnrs_cfg.sv */
// APB configuration register file for the MIDI note router.
`default_nettype none

module mnrs_cfg
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output mnrs_pkg::cfg_t     cfg
);

    mnrs_pkg::cfg_t     cfg_reg;
    mnrs_pkg::cfg_t     cfg_next;
    logic               wr_en;
    logic [2:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                mnrs_pkg::REG_TARGET_CHANNEL:    cfg_next.target_channel    = pwdata[3:0];
                mnrs_pkg::REG_CHANNEL_FILTER:    cfg_next.channel_filter    = pwdata[4:0];
                mnrs_pkg::REG_TRANSPOSE:         cfg_next.transpose         = pwdata[6:0];
                mnrs_pkg::REG_BEND_RANGE:        cfg_next.bend_range        = pwdata[5:0];
                mnrs_pkg::REG_SUSTAIN_THRESHOLD: cfg_next.sustain_threshold = pwdata[6:0];
                default:                         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            mnrs_pkg::REG_TARGET_CHANNEL:    prdata = {28'd0, cfg_reg.target_channel};
            mnrs_pkg::REG_CHANNEL_FILTER:    prdata = {27'd0, cfg_reg.channel_filter};
            mnrs_pkg::REG_TRANSPOSE:         prdata = {25'd0, cfg_reg.transpose};
            mnrs_pkg::REG_BEND_RANGE:        prdata = {26'd0, cfg_reg.bend_range};
            mnrs_pkg::REG_SUSTAIN_THRESHOLD: prdata = {25'd0, cfg_reg.sustain_threshold};
            default:                         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_channel    <= 4'd0;
            cfg_reg.channel_filter    <= 5'd0;
            cfg_reg.transpose         <= 7'sd0;
            cfg_reg.bend_range        <= 6'd2;
            cfg_reg.sustain_threshold <= 7'd64;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/mnrs_core.sv */
// Message decode, key bookkeeping and result generation: one request per cycle while room is set.
`default_nettype none

module mnrs_core
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire mnrs_pkg::cfg_t cfg,
    input  wire logic           msg_valid,
    input  wire mnrs_pkg::msg_t msg,
    input  wire logic           room,
    output logic                take,
    output mnrs_pkg::push_t     push
);

    localparam int GW = mnrs_pkg::GROUP_WIDTH;

    logic [mnrs_pkg::GROUPS-1:0][GW-1:0] sounding_reg;
    logic [mnrs_pkg::GROUPS-1:0][GW-1:0] sounding_next;
    logic [mnrs_pkg::GROUPS-1:0][GW-1:0] held_reg;
    logic [mnrs_pkg::GROUPS-1:0][GW-1:0] held_next;
    logic                                pedal_reg;
    logic                                pedal_next;
    logic [31:0]                         act_reg;
    logic [31:0]                         act_next;

    logic                                filter_ok;
    logic [8:0]                          pitch9;
    logic                                in_range;
    logic [mnrs_pkg::NOTE_COUNT-1:0]     note_bit;
    logic signed [14:0]                  wheel_diff;
    logic signed [20:0]                  bend_prod;
    logic                                counted;
    logic                                pedal_req;
    logic [mnrs_pkg::NUM_W-1:0]          num;
    mnrs_pkg::result_t                   base;
    mnrs_pkg::result_t [mnrs_pkg::MAX_RESULTS-1:0] items;

    assign filter_ok = (cfg.channel_filter == 5'd0) || (msg.midi_channel == cfg.channel_filter);

    // Nine-bit sum: the top two bits are zero exactly when the note stays in 0..127.
    assign pitch9   = {2'b00, msg.data_number} + {{2{cfg.transpose[6]}}, cfg.transpose};
    assign in_range = (pitch9[8:7] == 2'b00);
    assign note_bit = {{(mnrs_pkg::NOTE_COUNT-1){1'b0}}, 1'b1} << pitch9[6:0];

    assign wheel_diff = $signed({1'b0, msg.wheel_value}) - $signed({1'b0, mnrs_pkg::WHEEL_CENTER});
    assign bend_prod  = wheel_diff * $signed({1'b0, cfg.bend_range});

    assign pedal_req = (msg.data_value >= cfg.sustain_threshold);

    always_comb
    begin
        sounding_next = sounding_reg;
        held_next     = held_reg;
        pedal_next    = pedal_reg;
        counted       = 1'b0;
        num           = '0;

        base             = '0;
        base.out_channel = cfg.target_channel;
        items            = {mnrs_pkg::MAX_RESULTS{base}};

        unique case (msg.mode) inside
            mnrs_pkg::MODE_CLEAR, mnrs_pkg::MODE_PANIC:
            begin
                if (msg.mode == mnrs_pkg::MODE_PANIC)
                begin
                    items[0].event_kind = mnrs_pkg::EV_ALL_OFF;
                    items[1].event_kind = mnrs_pkg::EV_BEND;
                    items[2].event_kind = mnrs_pkg::EV_MOD;
                    num = 2'd3;
                end
                else
                begin
                    items[0].event_kind = mnrs_pkg::EV_BEND;
                    items[1].event_kind = mnrs_pkg::EV_MOD;
                    num = 2'd2;
                end
                sounding_next = '0;
                held_next     = '0;
                pedal_next    = 1'b0;
            end
            mnrs_pkg::MODE_NOTE_ON, mnrs_pkg::MODE_NOTE_OFF:
            begin
                if (filter_ok && in_range)
                begin
                    counted = 1'b1;
                    if (msg.mode == mnrs_pkg::MODE_NOTE_ON && msg.data_value != 7'd0)
                    begin
                        held_next     = held_reg & ~note_bit;
                        sounding_next = sounding_reg | note_bit;
                        items[0].event_kind     = mnrs_pkg::EV_NOTE_ON;
                        items[0].note_pitch     = pitch9[6:0];
                        items[0].note_velocity  = msg.data_value;
                        items[0].source_channel = msg.midi_channel;
                        num = 2'd1;
                    end
                    else if (pedal_reg)
                    begin
                        // The pedal defers the note-off; only a sounding key is held.
                        held_next = held_reg | (sounding_reg & note_bit);
                    end
                    else
                    begin
                        sounding_next = sounding_reg & ~note_bit;
                        items[0].event_kind     = mnrs_pkg::EV_NOTE_OFF;
                        items[0].note_pitch     = pitch9[6:0];
                        items[0].source_channel = msg.midi_channel;
                        num = 2'd1;
                    end
                end
            end
            mnrs_pkg::MODE_WHEEL:
            begin
                if (filter_ok)
                begin
                    counted = 1'b1;
                    items[0].event_kind  = mnrs_pkg::EV_BEND;
                    items[0].bend_amount = bend_prod[19:0];
                    num = 2'd1;
                end
            end
            mnrs_pkg::MODE_CONTROL:
            begin
                if (filter_ok)
                begin
                    counted = 1'b1;
                    if (msg.data_number == mnrs_pkg::CC_MOD)
                    begin
                        items[0].event_kind        = mnrs_pkg::EV_MOD;
                        items[0].modulation_amount = msg.data_value;
                        num = 2'd1;
                    end
                    else if (msg.data_number == mnrs_pkg::CC_SUSTAIN)
                    begin
                        pedal_next = pedal_req;
                        if (pedal_reg && !pedal_req)
                        begin
                            // Pedal lift: release each half that has held keys, low half first.
                            sounding_next = sounding_reg & ~held_reg;
                            held_next     = '0;
                            if (held_reg[0] != '0)
                            begin
                                items[0].event_kind   = mnrs_pkg::EV_RELEASE;
                                items[0].group_index  = 1'b0;
                                items[0].release_mask = held_reg[0];
                                if (held_reg[1] != '0)
                                begin
                                    items[1].event_kind   = mnrs_pkg::EV_RELEASE;
                                    items[1].group_index  = 1'b1;
                                    items[1].release_mask = held_reg[1];
                                    num = 2'd2;
                                end
                                else
                                begin
                                    num = 2'd1;
                                end
                            end
                            else if (held_reg[1] != '0)
                            begin
                                items[0].event_kind   = mnrs_pkg::EV_RELEASE;
                                items[0].group_index  = 1'b1;
                                items[0].release_mask = held_reg[1];
                                num = 2'd1;
                            end
                        end
                    end
                    else if (msg.data_number == mnrs_pkg::CC_SOUND_OFF ||
                             msg.data_number == mnrs_pkg::CC_NOTES_OFF)
                    begin
                        items[0].event_kind = mnrs_pkg::EV_ALL_OFF;
                        items[1].event_kind = mnrs_pkg::EV_BEND;
                        items[2].event_kind = mnrs_pkg::EV_MOD;
                        num = 2'd3;
                        sounding_next = '0;
                        held_next     = '0;
                        pedal_next    = 1'b0;
                    end
                end
            end
            default:
            begin
                num = '0;
            end
        endcase

        act_next = counted ? act_reg + 32'd1 : act_reg;

        for (int i = 0; i < mnrs_pkg::MAX_RESULTS; i++)
        begin
            items[i].activity_count = act_next;
            items[i].last_of_run    = (mnrs_pkg::NUM_W'(i + 1) == num);
        end
    end

    assign take       = msg_valid && room;
    assign push.count = take ? num : '0;
    assign push.items = items;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sounding_reg <= '0;
            held_reg     <= '0;
            pedal_reg    <= 1'b0;
            act_reg      <= 32'd0;
        end
        else if (take)
        begin
            sounding_reg <= sounding_next;
            held_reg     <= held_next;
            pedal_reg    <= pedal_next;
            act_reg      <= act_next;
        end
    end

`ifndef SYNTH
    a_held_needs_pedal: assert property (@(posedge clk) disable iff (!rst_n)
        !pedal_reg |-> (held_reg == '0))
        else $error("held keys present while the pedal is up");

    a_held_subset_sounding: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg & ~sounding_reg) == '0)
        else $error("a held key is not sounding");

    a_activity_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (act_reg == $past(act_reg) || act_reg == $past(act_reg) + 32'd1))
        else $error("activity counter moved by more than one");
`endif

endmodule

`default_nettype wire

/* rtl/mnrs_fifo.sv */
// Small result queue: takes up to three results per cycle, gives one on out_ready.
`default_nettype none

module mnrs_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mnrs_pkg::push_t push,
    output logic                 room,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output mnrs_pkg::result_t    head
);

    localparam int PW = mnrs_pkg::PTR_W;
    localparam int CW = mnrs_pkg::CNT_W;

    mnrs_pkg::result_t  mem_reg [mnrs_pkg::RES_DEPTH];
    logic [PW-1:0]      rd_ptr_reg;
    logic [PW-1:0]      rd_ptr_next;
    logic [PW-1:0]      wr_ptr_reg;
    logic [PW-1:0]      wr_ptr_next;
    logic [CW-1:0]      cnt_reg;
    logic [CW-1:0]      cnt_next;
    logic               pop;

    // Room is judged on the stored count only, so a full burst of three always fits.
    assign room      = (cnt_reg <= CW'(mnrs_pkg::RES_DEPTH - mnrs_pkg::MAX_RESULTS));
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign head      = mem_reg[rd_ptr_reg];

    assign rd_ptr_next = rd_ptr_reg + PW'(pop);
    assign wr_ptr_next = wr_ptr_reg + PW'(push.count);
    assign cnt_next    = cnt_reg + CW'(push.count) - CW'(pop);

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < mnrs_pkg::MAX_RESULTS; i++)
        begin
            if (mnrs_pkg::NUM_W'(i) < push.count)
            begin
                mem_reg[wr_ptr_reg + PW'(i)] <= push.items[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(mnrs_pkg::RES_DEPTH))
        else $error("result queue count beyond its depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != '0) |-> (({1'b0, cnt_reg} + (CW + 1)'(push.count))
                                <= (CW + 1)'(mnrs_pkg::RES_DEPTH)))
        else $error("burst of results overflows the queue");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> (cnt_reg == $past(cnt_reg) + CW'($past(push.count)) - CW'($past(pop))))
        else $error("queue count does not follow pushes and pops");
`endif

endmodule

`default_nettype wire

/* rtl/midi_note_router_with_sustain.sv */
// Top level of the MIDI note router with sustain pedal tracking.
// Each request passes through the input register and the result queue to the output.
// Throughput: one request per cycle while each makes at most one result and the
// output is ready; results leave the queue one at a time, and a new request enters
// the core only while the four-entry result queue holds at most one result.
// Reset: asynchronous, active low; clears configuration to defaults, the key bitmaps,
// the pedal, the activity counter and the result queue.
`default_nettype none

module midi_note_router_with_sustain
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    // APB configuration port
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [4:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // Message input
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // midi_channel[4:0], data_number[11:5], data_value[18:12], wheel_value[32:19]
    input  wire logic [39:0]   s_tdata,
    // mode[2:0]
    input  wire logic [2:0]    s_tuser,
    // Event output
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // out_channel[3:0], note_pitch[10:4], note_velocity[17:11], source_channel[22:18],
    // bend_amount[42:23], modulation_amount[49:43], group_index[50],
    // release_mask[114:51], activity_count[146:115]
    output logic [151:0]       m_tdata,
    // event_kind[2:0]
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);

    mnrs_pkg::cfg_t     cfg;
    mnrs_pkg::msg_t     msg_reg;
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               take;
    logic               room;
    mnrs_pkg::push_t    push;
    mnrs_pkg::result_t  head;

    mnrs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Input register refills in the same cycle the core takes its request.
    assign s_tready      = !in_valid_reg || take;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            msg_reg.mode         <= mnrs_pkg::mode_t'(s_tuser);
            msg_reg.midi_channel <= s_tdata[4:0];
            msg_reg.data_number  <= s_tdata[11:5];
            msg_reg.data_value   <= s_tdata[18:12];
            msg_reg.wheel_value  <= s_tdata[32:19];
        end
    end

    mnrs_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .msg_valid (in_valid_reg),
        .msg       (msg_reg),
        .room      (room),
        .take      (take),
        .push      (push)
    );

    mnrs_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {5'd0,
                      head.activity_count,
                      head.release_mask,
                      head.group_index,
                      head.modulation_amount,
                      head.bend_amount,
                      head.source_channel,
                      head.note_velocity,
                      head.note_pitch,
                      head.out_channel};
    assign m_tuser = head.event_kind;
    assign m_tlast = head.last_of_run;

endmodule

`default_nettype wire
